// ----- rtl/core/podi_pkg.sv -----
// ---------------------------------------------------------------------------
// podi_pkg
// Shared types, constants, arctangent table and control store for the
// planar odometry integrator.
// ---------------------------------------------------------------------------
package podi_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ITER_W        = $clog2(CORDIC_STAGES);
  localparam int CW            = 34;  // CORDIC datapath width
  localparam int STEP_W        = 5;
  localparam int IN_DATA_W     = 136;
  localparam int OUT_DATA_W    = 112;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STAGES - 1);
  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(34'sh026DD3B6A);

  localparam logic [1:0] ACT_POSE = 2'd0;
  localparam logic [1:0] ACT_VEL  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  localparam logic [STEP_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [STEP_W-1:0] ST_C1_INIT = 5'd1;
  localparam logic [STEP_W-1:0] ST_C1_ITER = 5'd2;
  localparam logic [STEP_W-1:0] ST_C1_FIN  = 5'd3;
  localparam logic [STEP_W-1:0] ST_M0      = 5'd4;
  localparam logic [STEP_W-1:0] ST_M1      = 5'd5;
  localparam logic [STEP_W-1:0] ST_M2      = 5'd6;
  localparam logic [STEP_W-1:0] ST_M3      = 5'd7;
  localparam logic [STEP_W-1:0] ST_M4      = 5'd8;
  localparam logic [STEP_W-1:0] ST_M5      = 5'd9;
  localparam logic [STEP_W-1:0] ST_M6      = 5'd10;
  localparam logic [STEP_W-1:0] ST_M7      = 5'd11;
  localparam logic [STEP_W-1:0] ST_M8      = 5'd12;
  localparam logic [STEP_W-1:0] ST_M9      = 5'd13;
  localparam logic [STEP_W-1:0] ST_C2_INIT = 5'd14;
  localparam logic [STEP_W-1:0] ST_C2_ITER = 5'd15;
  localparam logic [STEP_W-1:0] ST_C2_FIN  = 5'd16;
  localparam logic [STEP_W-1:0] ST_OUT     = 5'd17;

  typedef enum logic [1:0] {
    CND_SEQ,
    CND_DISPATCH,
    CND_LOOP,
    CND_HOLD
  } cond_t;

  typedef enum logic [2:0] {
    COP_NONE,
    COP_INIT_HEAD,
    COP_INIT_HALF,
    COP_ITER,
    COP_FIN
  } cop_t;

  typedef enum logic [2:0] {
    MUL_VF_C,
    MUL_VS_S,
    MUL_VF_S,
    MUL_VS_C,
    MUL_ACC_EL,
    MUL_YAW_EL
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_X,
    WR_Y,
    WR_HEAD,
    WR_OUT
  } wr_t;

  typedef struct packed {
    logic [STEP_W-1:0] next;
    cond_t             cond;
    cop_t              cop;
    mul_sel_t          mul_sel;
    acc_op_t           acc_op;
    wr_t               wr;
  } ctrl_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      5'd20:   r = 32'h0000028C;
      5'd21:   r = 32'h00000146;
      5'd22:   r = 32'h000000A3;
      5'd23:   r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // round half up to Q1.15 and clamp
  function automatic logic signed [15:0] sat_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    logic signed [15:0]   r;
    t = (v + CW'(34'sd16384)) >>> 15;
    if (t > CW'(34'sd32767)) begin
      r = 16'sh7FFF;
    end else if (t < -CW'(34'sd32768)) begin
      r = 16'sh8000;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] a);
    ctrl_t w;
    case (a)
      ST_IDLE:    w = '{ST_C1_INIT, CND_DISPATCH, COP_NONE, MUL_VF_C, ACC_NONE, WR_NONE};
      ST_C1_INIT: w = '{ST_C1_ITER, CND_SEQ, COP_INIT_HEAD, MUL_VF_C, ACC_NONE, WR_NONE};
      ST_C1_ITER: w = '{ST_C1_FIN, CND_LOOP, COP_ITER, MUL_VF_C, ACC_NONE, WR_NONE};
      ST_C1_FIN:  w = '{ST_M0, CND_SEQ, COP_FIN, MUL_VF_C, ACC_NONE, WR_NONE};
      ST_M0:      w = '{ST_M1, CND_SEQ, COP_NONE, MUL_VF_C, ACC_NONE, WR_NONE};
      ST_M1:      w = '{ST_M2, CND_SEQ, COP_NONE, MUL_VS_S, ACC_LOAD, WR_NONE};
      ST_M2:      w = '{ST_M3, CND_SEQ, COP_NONE, MUL_VS_S, ACC_SUB, WR_NONE};
      ST_M3:      w = '{ST_M4, CND_SEQ, COP_NONE, MUL_ACC_EL, ACC_NONE, WR_NONE};
      ST_M4:      w = '{ST_M5, CND_SEQ, COP_NONE, MUL_VF_S, ACC_NONE, WR_X};
      ST_M5:      w = '{ST_M6, CND_SEQ, COP_NONE, MUL_VS_C, ACC_LOAD, WR_NONE};
      ST_M6:      w = '{ST_M7, CND_SEQ, COP_NONE, MUL_VS_C, ACC_ADD, WR_NONE};
      ST_M7:      w = '{ST_M8, CND_SEQ, COP_NONE, MUL_ACC_EL, ACC_NONE, WR_NONE};
      ST_M8:      w = '{ST_M9, CND_SEQ, COP_NONE, MUL_YAW_EL, ACC_NONE, WR_Y};
      ST_M9:      w = '{ST_C2_INIT, CND_SEQ, COP_NONE, MUL_YAW_EL, ACC_NONE, WR_HEAD};
      ST_C2_INIT: w = '{ST_C2_ITER, CND_SEQ, COP_INIT_HALF, MUL_VF_C, ACC_NONE, WR_NONE};
      ST_C2_ITER: w = '{ST_C2_FIN, CND_LOOP, COP_ITER, MUL_VF_C, ACC_NONE, WR_NONE};
      ST_C2_FIN:  w = '{ST_OUT, CND_SEQ, COP_FIN, MUL_VF_C, ACC_NONE, WR_NONE};
      ST_OUT:     w = '{ST_IDLE, CND_HOLD, COP_NONE, MUL_VF_C, ACC_NONE, WR_OUT};
      default:    w = '{ST_IDLE, CND_SEQ, COP_NONE, MUL_VF_C, ACC_NONE, WR_NONE};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/planar_odometry_integrator.sv -----
// ---------------------------------------------------------------------------
// planar_odometry_integrator
// Dead-reckoning pose integrator run by a microcoded sequencer over one
// shared multiplier and one iterative CORDIC stage.
// Set-pose and set-velocity requests: taken in the idle step, no result.
// Tick request: sequenced through a heading CORDIC pass, the multiply steps
// and a half-angle CORDIC pass on the single CORDIC iteration stage; no new
// request is taken until the sequencer is idle again. A finished result waits in the output register.
// Synchronous reset clears the pose, the velocity terms and the sequencer.
// ---------------------------------------------------------------------------
module planar_odometry_integrator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pose_x, pose_y, speed_fwd, speed_side, turn_rate, elapsed, zero pad
  input  logic [podi_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // action
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_x, out_y, out_heading, quat_z, quat_w
  output logic [podi_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import podi_pkg::*;

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  ctrl_t             cw;

  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;
  logic signed [15:0] vel_fwd;
  logic signed [15:0] vel_side;
  logic signed [17:0] yaw_rate;
  logic [15:0]        el;

  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic signed [CW-1:0] cz;
  logic                 flip;
  logic [ITER_W-1:0]    iter;
  logic signed [15:0]   sn;
  logic signed [15:0]   cs;

  logic signed [32:0] acc;
  logic signed [32:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [49:0] prod;
  logic signed [49:0] pos_rnd;
  logic signed [49:0] head_rnd;
  logic signed [32:0] pos_cur;
  logic signed [32:0] pos_sum;
  logic signed [31:0] pos_sat;

  logic [31:0]          ang;
  logic                 ang_flip;
  logic [31:0]          ang_adj;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] atan_v;
  logic signed [CW-1:0] xf;
  logic signed [CW-1:0] yf;

  logic accept;
  logic out_busy;

  assign cw            = ucode(step);
  assign s_axis_tready = (step == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_busy      = m_axis_tvalid && !m_axis_tready;

  always_comb begin
    step_next = step;
    case (cw.cond)
      CND_DISPATCH: begin
        if (accept && s_axis_tuser == ACT_TICK) begin
          step_next = cw.next;
        end
      end
      CND_LOOP: begin
        if (iter == ITER_LAST) begin
          step_next = cw.next;
        end
      end
      CND_HOLD: begin
        if (!out_busy) begin
          step_next = cw.next;
        end
      end
      default: step_next = cw.next;
    endcase
  end

  // CORDIC operand prep
  always_comb begin
    ang = (cw.cop == COP_INIT_HALF) ? {1'b0, heading, 15'h0} : {heading, 16'h0};
    ang_flip = ang[31] ^ ang[30];
    ang_adj  = ang_flip ? (ang ^ 32'h8000_0000) : ang;
    dx       = cy >>> iter;
    dy       = cx >>> iter;
    atan_v   = CW'(atan_entry(5'(iter)));
    xf       = flip ? -cx : cx;
    yf       = flip ? -cy : cy;
  end

  // shared multiplier operands
  always_comb begin
    case (cw.mul_sel)
      MUL_VF_C: begin
        mul_a = 33'(vel_fwd);
        mul_b = 17'(cs);
      end
      MUL_VS_S: begin
        mul_a = 33'(vel_side);
        mul_b = 17'(sn);
      end
      MUL_VF_S: begin
        mul_a = 33'(vel_fwd);
        mul_b = 17'(sn);
      end
      MUL_VS_C: begin
        mul_a = 33'(vel_side);
        mul_b = 17'(cs);
      end
      MUL_ACC_EL: begin
        mul_a = acc;
        mul_b = $signed({1'b0, el});
      end
      MUL_YAW_EL: begin
        mul_a = 33'(yaw_rate);
        mul_b = $signed({1'b0, el});
      end
      default: begin
        mul_a = acc;
        mul_b = $signed({1'b0, el});
      end
    endcase
  end

  always_comb begin
    pos_rnd  = prod + 50'sh000_0400_0000;
    head_rnd = prod + 50'sh000_0000_8000;
    pos_cur  = (cw.wr == WR_Y) ? 33'(pos_y) : 33'(pos_x);
    pos_sum  = pos_cur + 33'($signed(pos_rnd[49:27]));
    if (pos_sum[32] != pos_sum[31]) begin
      pos_sat = pos_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      pos_sat = pos_sum[31:0];
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
      heading       <= '0;
      vel_fwd       <= '0;
      vel_side      <= '0;
      yaw_rate      <= '0;
    end else begin
      step <= step_next;
      if (accept) begin
        case (s_axis_tuser)
          ACT_POSE: begin
            pos_x <= s_axis_tdata[31:0];
            pos_y <= s_axis_tdata[63:32];
          end
          ACT_VEL: begin
            vel_fwd  <= s_axis_tdata[79:64];
            vel_side <= s_axis_tdata[95:80];
            yaw_rate <= s_axis_tdata[113:96];
          end
          default: ;
        endcase
      end
      case (cw.wr)
        WR_X:    pos_x <= pos_sat;
        WR_Y:    pos_y <= pos_sat;
        WR_HEAD: heading <= heading + head_rnd[31:16];
        default: ;
      endcase
      if (cw.wr == WR_OUT && !out_busy) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (accept) begin
      el <= s_axis_tdata[129:114];
    end
    case (cw.acc_op)
      ACC_LOAD: acc <= prod[32:0];
      ACC_ADD:  acc <= acc + prod[32:0];
      ACC_SUB:  acc <= acc - prod[32:0];
      default: ;
    endcase
    case (cw.cop)
      COP_INIT_HEAD, COP_INIT_HALF: begin
        cx   <= CORDIC_X0;
        cy   <= '0;
        cz   <= CW'($signed(ang_adj));
        flip <= ang_flip;
        iter <= '0;
      end
      COP_ITER: begin
        if (!cz[CW-1]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - atan_v;
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + atan_v;
        end
        iter <= iter + 1'b1;
      end
      COP_FIN: begin
        cs <= sat_q15(xf);
        sn <= sat_q15(yf);
      end
      default: ;
    endcase
    if (cw.wr == WR_OUT && !out_busy) begin
      m_axis_tdata <= {cs, sn, heading, pos_y, pos_x};
    end
  end

endmodule

// ----- sim/podi_checker.sv -----
// ---------------------------------------------------------------------------
// podi_checker
// Watches both stream channels of the odometry integrator. Every accepted
// pose, velocity or tick request updates a local copy of the pose and velocity
// state; a tick request also queues the expected pose and quaternion. Every
// accepted result is compared field by field with the oldest queued pose.
// ---------------------------------------------------------------------------
module podi_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_valid,
  input  logic                            s_ready,
  input  logic [podi_pkg::IN_DATA_W-1:0]  s_data,
  input  logic [1:0]                      s_user,
  input  logic                            m_valid,
  input  logic                            m_ready,
  input  logic [podi_pkg::OUT_DATA_W-1:0] m_data,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import podi_pkg::*;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [15:0]        head;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } pose_t;

  localparam logic [31:0] ARCTAN [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  logic signed [31:0] pos_x, pos_y;
  logic [15:0]        head;
  logic signed [15:0] vel_f, vel_s;
  logic signed [17:0] yaw;
  pose_t              pose_expected [$];

  initial errors = 0;
  initial pending = 0;

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // rotation-mode CORDIC, angle in 2^32 units per turn
  function automatic void sin_cos(input logic [31:0] ang, output longint sn,
                                  output longint cs);
    longint      x, y, z, nx, dx, dy;
    logic [31:0] probe;
    logic        flip;
    probe = ang + 32'h4000_0000;
    flip = probe[31];
    if (flip) ang = ang ^ 32'h8000_0000;
    x = 64'sh26DD3B6A;
    y = 0;
    z = longint'($signed(ang));
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        nx = x - dx;
        y = y + dy;
        z = z - longint'(ARCTAN[i]);
      end else begin
        nx = x + dx;
        y = y - dy;
        z = z + longint'(ARCTAN[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = clamp((x + 16384) >>> 15, -32768, 32767);
    sn = clamp((y + 16384) >>> 15, -32768, 32767);
  endfunction

  task automatic integrate_tick(input logic [15:0] elapsed);
    longint sn, cs, rx, ry, el, dth, nx, ny;
    pose_t  p;
    el = longint'(elapsed);
    sin_cos({head, 16'h0000}, sn, cs);
    rx = longint'(vel_f) * cs - longint'(vel_s) * sn;
    ry = longint'(vel_f) * sn + longint'(vel_s) * cs;
    nx = longint'(pos_x) + ((rx * el + (longint'(1) <<< 26)) >>> 27);
    ny = longint'(pos_y) + ((ry * el + (longint'(1) <<< 26)) >>> 27);
    pos_x = 32'(clamp(nx, -64'sd2147483648, 64'sd2147483647));
    pos_y = 32'(clamp(ny, -64'sd2147483648, 64'sd2147483647));
    dth = (longint'(yaw) * el + 32768) >>> 16;
    head = head + dth[15:0];
    sin_cos({1'b0, head, 15'h0000}, sn, cs);
    p.x = pos_x;
    p.y = pos_y;
    p.head = head;
    p.qz = sn[15:0];
    p.qw = cs[15:0];
    pose_expected.push_back(p);
  endtask

  task automatic report(input string field, input longint want, input longint got);
    $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, field, want, got);
    errors++;
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] d);
    pose_t w;
    if (pose_expected.size() == 0) begin
      $display("%0t ns: unexpected result, expected none actual %0h", $time, d);
      errors++;
    end else begin
      w = pose_expected.pop_front();
      if (d[31:0] !== w.x) report("out_x", w.x, d[31:0]);
      if (d[63:32] !== w.y) report("out_y", w.y, d[63:32]);
      if (d[79:64] !== w.head) report("out_heading", w.head, d[79:64]);
      if (d[95:80] !== w.qz) report("quat_z", w.qz, d[95:80]);
      if (d[111:96] !== w.qw) report("quat_w", w.qw, d[111:96]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pos_x = '0;
      pos_y = '0;
      head = '0;
      vel_f = '0;
      vel_s = '0;
      yaw = '0;
      pose_expected.delete();
    end else begin
      if (m_valid && m_ready) check_result(m_data);
      if (s_valid && s_ready) begin
        case (s_user)
          ACT_POSE: begin
            pos_x = s_data[31:0];
            pos_y = s_data[63:32];
          end
          ACT_VEL: begin
            vel_f = s_data[79:64];
            vel_s = s_data[95:80];
            yaw = s_data[113:96];
          end
          ACT_TICK: integrate_tick(s_data[129:114]);
          default: ;
        endcase
      end
    end
    pending <= pose_expected.size();
  end

endmodule

// ----- sim/planar_odometry_integrator_tb.sv -----
// ---------------------------------------------------------------------------
// planar_odometry_integrator_tb
// Drives pose, velocity, tick and spare requests into the integrator with
// random gaps and output stalls, including one long output hold-off that
// backs the block up. A directed opening covers field extremes, position
// saturation, heading wrap and unity cosine; random traffic follows.
// ---------------------------------------------------------------------------
module planar_odometry_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import podi_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [IN_DATA_W-1:0]  s_data = '0;
  logic [1:0]            s_user = '0;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [OUT_DATA_W-1:0] m_data;
  int                    fail_count;
  int                    pending;
  bit                    hold = 1'b0;
  bit                    steady = 1'b0;
  int                    offered = 0;
  int                    stall_left = 0;

  planar_odometry_integrator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  podi_checker chk (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .s_user  (s_user),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .errors  (fail_count),
    .pending (pending)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // output side: per-result stall counted while a result is waiting
  always @(posedge clk) begin : sink
    int n;
    if (m_valid && m_ready) begin
      n = steady ? 0 : $urandom_range(0, 13);
      stall_left <= n;
      m_ready <= (n == 0) && !hold;
    end else if (hold) begin
      m_ready <= 1'b0;
    end else if (stall_left > 0) begin
      if (m_valid) stall_left <= stall_left - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // long output hold-off so the block backs up onto its input
  initial begin
    wait (offered >= 400);
    @(posedge clk);
    hold <= 1'b1;
    repeat (500) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic offer(input logic [1:0] act, input logic [31:0] px, input logic [31:0] py,
                       input logic [31:0] vf, input logic [31:0] vs,
                       input logic [31:0] tr, input logic [31:0] el);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user <= act;
    s_data <= {6'd0, el[15:0], tr[17:0], vs[15:0], vf[15:0], py, px};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    offered++;
  endtask

  initial begin
    int pick;
    logic [1:0] act;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // heading zero: cosine of exactly one
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 32'h0000);
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF);
    offer(ACT_VEL, $urandom, $urandom, 32'h7FFF, 32'h8000, 32'h1FFFF, $urandom);
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF);
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 32'h0001);
    // drive the position into both saturation limits
    offer(ACT_POSE, 32'h7FFFFFFF, 32'h7FFFFFFF, $urandom, $urandom, $urandom, $urandom);
    offer(ACT_VEL, $urandom, $urandom, 32'h7FFF, 32'h7FFF, 32'h00000, $urandom);
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF);
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF);
    offer(ACT_POSE, 32'h80000000, 32'h80000000, $urandom, $urandom, $urandom, $urandom);
    offer(ACT_VEL, $urandom, $urandom, 32'h8000, 32'h8000, 32'h20000, $urandom);
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF);
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF);
    offer(ACT_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    offer(ACT_POSE, 32'h0, 32'h0, $urandom, $urandom, $urandom, $urandom);
    offer(ACT_VEL, $urandom, $urandom, 32'hFFFF, 32'h0001, 32'h3FFFF, $urandom);
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 32'h8000);
    // heading wraps past a full turn
    offer(ACT_VEL, $urandom, $urandom, 32'h0000, 32'h0000, 32'h10000, $urandom);
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 32'hFFFF);
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 32'h8000);
    offer(ACT_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    offer(ACT_POSE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    offer(ACT_VEL, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    offer(ACT_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);

    for (int k = 0; k < 1200; k++) begin
      steady <= ((k / 100) % 4) == 3;
      pick = $urandom_range(0, 99);
      if (pick < 60) act = ACT_TICK;
      else if (pick < 80) act = ACT_VEL;
      else if (pick < 95) act = ACT_POSE;
      else act = ACT_SPARE;
      offer(act, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    s_valid <= 1'b0;
    steady <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
